### sv/sbcu_pkg.sv
// Shared types, codes and tables for the subband coefficient unpacker.
// Depends on nothing; the symbol decoder and the top level import it.
package sbcu_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_LEVELS = 2'd0;
    localparam logic [1:0] REG_ROWS   = 2'd1;

    // Parse phases of the stream.
    localparam logic [2:0] PH_EXP  = 3'd0;
    localparam logic [2:0] PH_STEP = 3'd1;
    localparam logic [2:0] PH_CODE = 3'd2;
    localparam logic [2:0] PH_BAND = 3'd3;
    localparam logic [2:0] PH_RAW  = 3'd4;

    // Band format codes with a meaning of their own.
    localparam logic [4:0] FMT_ZERO = 5'd0;
    localparam logic [4:0] FMT_RAW  = 5'd31;

    // Result count of one input byte past which parsing pauses before its next parse action.
    localparam logic [4:0] RES_LIMIT = 5'd21;

    // One decoded symbol: up to three level indexes or one zero run.
    typedef struct packed {
        logic [4:0]  take;
        logic        is_zero;
        logic [1:0]  zrun;
        logic [1:0]  count;
        logic [15:0] k0;
        logic [15:0] k1;
        logic [15:0] k2;
    } t_sym;

    // One result item.
    typedef struct packed {
        logic [31:0] coeff;
        logic [14:0] band;
        logic [11:0] row;
        logic [11:0] run_len;
        logic        raw_mode;
        logic        bad_code;
        logic        block_end;
    } t_res;

    // Bits a format code needs before a symbol can be decoded; zero marks
    // a code that is not a linear or symbol format.
    function automatic logic [4:0] need_bits(input logic [4:0] f);
        logic [4:0] n;
        case (f)
            5'd17: n = 5'd3;
            5'd18: n = 5'd2;
            5'd19: n = 5'd5;
            5'd20: n = 5'd4;
            5'd21: n = 5'd3;
            5'd22: n = 5'd7;
            5'd23: n = 5'd5;
            5'd24: n = 5'd4;
            5'd26: n = 5'd5;
            5'd27: n = 5'd4;
            5'd29: n = 5'd7;
            5'd31: n = 5'd16;
            default: begin
                if (f >= 5'd3 && f <= 5'd16) n = f;
                else n = 5'd0;
            end
        endcase
        return n;
    endfunction

    // Quotient of a small value by a small constant, by compares.
    function automatic logic [3:0] small_div(input logic [6:0] m, input int unsigned d);
        logic [3:0] q;
        q = 4'd0;
        for (int i = 1; i <= 10; i++) begin
            if (int'(m) >= i * int'(d)) q = 4'(i);
        end
        return q;
    endfunction

endpackage

### sv/sbcu_symdec.sv
// Symbol decoder: turns the low buffer bits and a band format code into
// the bit count used and the level indexes or zero run. Uses sbcu_pkg.
module sbcu_symdec import sbcu_pkg::*; (
    input  logic [15:0] i_bits,
    input  logic [4:0]  i_fmt,
    output t_sym        o_sym
);

    logic [6:0]  m7;
    logic [3:0]  q_hi;
    logic [3:0]  q_mid;
    logic [6:0]  rem_hi;
    logic [16:0] lin_mask;
    logic [15:0] lin_val;

    assign m7 = i_bits[6:0];

    // Packed triples and pairs: split into digits by constant compares.
    always_comb begin
        q_hi   = 4'd0;
        q_mid  = 4'd0;
        rem_hi = 7'd0;
        case (i_fmt)
            5'd19: begin
                q_hi   = small_div({2'b0, m7[4:0]}, 9);
                rem_hi = 7'({2'b0, m7[4:0]} - 7'(q_hi) * 7'd9);
                q_mid  = small_div(rem_hi, 3);
            end
            5'd22: begin
                q_hi   = small_div(m7, 25);
                rem_hi = 7'(m7 - 7'(q_hi) * 7'd25);
                q_mid  = small_div(rem_hi, 5);
            end
            5'd29: begin
                q_hi   = small_div(m7, 11);
                rem_hi = 7'(m7 - 7'(q_hi) * 7'd11);
            end
            default: begin
                q_hi = 4'd0;
            end
        endcase
    end

    // Linear k-bit value minus half its range.
    assign lin_mask = (17'd1 << i_fmt) - 17'd1;
    assign lin_val  = 16'(({1'b0, i_bits} & lin_mask) - (17'd1 << (i_fmt - 5'd1)));

    always_comb begin
        o_sym         = '0;
        o_sym.count   = 2'd1;
        o_sym.zrun    = 2'd1;
        case (i_fmt)
            5'd17: begin
                if (!i_bits[0]) begin
                    o_sym.take = 5'd1; o_sym.is_zero = 1'b1; o_sym.zrun = 2'd2;
                end else if (!i_bits[1]) begin
                    o_sym.take = 5'd2; o_sym.is_zero = 1'b1;
                end else begin
                    o_sym.take = 5'd3; o_sym.k0 = i_bits[2] ? 16'sd1 : -16'sd1;
                end
            end
            5'd18: begin
                if (!i_bits[0]) begin
                    o_sym.take = 5'd1; o_sym.is_zero = 1'b1;
                end else begin
                    o_sym.take = 5'd2; o_sym.k0 = i_bits[1] ? 16'sd1 : -16'sd1;
                end
            end
            5'd19: begin
                o_sym.take  = 5'd5;
                o_sym.count = 2'd3;
                if (i_bits[4:0] < 5'd27) begin
                    o_sym.k0 = 16'(int'(rem_hi) - 3 * int'(q_mid) - 1);
                    o_sym.k1 = 16'(int'(q_mid) - 1);
                    o_sym.k2 = 16'(int'(q_hi) - 1);
                end else begin
                    o_sym.k0 = -16'sd1; o_sym.k1 = -16'sd1; o_sym.k2 = -16'sd1;
                end
            end
            5'd20: begin
                if (!i_bits[0]) begin
                    o_sym.take = 5'd1; o_sym.is_zero = 1'b1; o_sym.zrun = 2'd2;
                end else if (!i_bits[1]) begin
                    o_sym.take = 5'd2; o_sym.is_zero = 1'b1;
                end else begin
                    o_sym.take = 5'd4;
                    if (i_bits[3]) o_sym.k0 = i_bits[2] ? 16'sd2 : 16'sd1;
                    else o_sym.k0 = i_bits[2] ? -16'sd1 : -16'sd2;
                end
            end
            5'd21: begin
                if (!i_bits[0]) begin
                    o_sym.take = 5'd1; o_sym.is_zero = 1'b1;
                end else begin
                    o_sym.take = 5'd3;
                    if (i_bits[2]) o_sym.k0 = i_bits[1] ? 16'sd2 : 16'sd1;
                    else o_sym.k0 = i_bits[1] ? -16'sd1 : -16'sd2;
                end
            end
            5'd22: begin
                o_sym.take  = 5'd7;
                o_sym.count = 2'd3;
                if (m7 < 7'd125) begin
                    o_sym.k0 = 16'(int'(rem_hi) - 5 * int'(q_mid) - 2);
                    o_sym.k1 = 16'(int'(q_mid) - 2);
                    o_sym.k2 = 16'(int'(q_hi) - 2);
                end else begin
                    o_sym.k0 = -16'sd2; o_sym.k1 = -16'sd2; o_sym.k2 = -16'sd2;
                end
            end
            5'd23: begin
                if (!i_bits[0]) begin
                    o_sym.take = 5'd1; o_sym.is_zero = 1'b1; o_sym.zrun = 2'd2;
                end else if (!i_bits[1]) begin
                    o_sym.take = 5'd2; o_sym.is_zero = 1'b1;
                end else if (!i_bits[2]) begin
                    o_sym.take = 5'd4; o_sym.k0 = i_bits[3] ? 16'sd1 : -16'sd1;
                end else begin
                    o_sym.take = 5'd5;
                    o_sym.k0 = i_bits[4] ? 16'({1'b0, i_bits[4:3]})
                                         : 16'(int'(i_bits[4:3]) - 3);
                end
            end
            5'd24: begin
                if (!i_bits[0]) begin
                    o_sym.take = 5'd1; o_sym.is_zero = 1'b1;
                end else if (!i_bits[1]) begin
                    o_sym.take = 5'd3; o_sym.k0 = i_bits[2] ? 16'sd1 : -16'sd1;
                end else begin
                    o_sym.take = 5'd4;
                    o_sym.k0 = i_bits[3] ? 16'({1'b0, i_bits[3:2]})
                                         : 16'(int'(i_bits[3:2]) - 3);
                end
            end
            5'd26: begin
                if (!i_bits[0]) begin
                    o_sym.take = 5'd1; o_sym.is_zero = 1'b1; o_sym.zrun = 2'd2;
                end else if (!i_bits[1]) begin
                    o_sym.take = 5'd2; o_sym.is_zero = 1'b1;
                end else begin
                    o_sym.take = 5'd5;
                    o_sym.k0 = i_bits[4] ? 16'(int'(i_bits[4:2]) - 3)
                                         : 16'(int'(i_bits[4:2]) - 4);
                end
            end
            5'd27: begin
                if (!i_bits[0]) begin
                    o_sym.take = 5'd1; o_sym.is_zero = 1'b1;
                end else begin
                    o_sym.take = 5'd4;
                    o_sym.k0 = i_bits[3] ? 16'(int'(i_bits[3:1]) - 3)
                                         : 16'(int'(i_bits[3:1]) - 4);
                end
            end
            5'd29: begin
                o_sym.take  = 5'd7;
                o_sym.count = 2'd2;
                if (m7 < 7'd121) begin
                    o_sym.k0 = 16'(int'(rem_hi) - 5);
                    o_sym.k1 = 16'(int'(q_hi) - 5);
                end else begin
                    o_sym.k0 = -16'sd5; o_sym.k1 = -16'sd5;
                end
            end
            default: begin
                // Linear formats, three to sixteen bits per value.
                o_sym.take = i_fmt;
                o_sym.k0   = lin_val;
            end
        endcase
    end

endmodule

### sv/subband_coefficient_unpacker_top.sv
// Channel   | Direction | Handshake                      | Payload
// input     | in        | i_valid / o_stall              | i_byte_in
// result    | out       | o_valid / i_stall              | o_coeff .. o_block_end
// config    | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Each byte enters while the block is idle; the sequencer then works through its parse actions (header
// field, band code, symbol, raw value) and through each value or zero run of a decoded symbol, and
// closes the byte by going idle again; o_stall stays high until then.
// The sequencer uses a single shared multiplier.
// A result stalled at the output holds the sequencer once a second result waits.
// Reset is synchronous and active low; it clears the parse state and control registers, not r_q, r_p, r_o.
// Depends on sbcu_pkg and sbcu_symdec.
module subband_coefficient_unpacker_top import sbcu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_byte_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_coeff,
    output logic [14:0]        o_band,
    output logic [11:0]        o_row,
    output logic [11:0]        o_run_len,
    output logic               o_raw_mode,
    output logic               o_bad_code,
    output logic               o_block_end,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOP  = 2'd1;
    localparam logic [1:0] S_LEVEL = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [31:0] r_buf, n_buf;
    logic [5:0]  r_cnt, n_cnt;
    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_step, n_step;
    logic [14:0] r_band, n_band;
    logic [11:0] r_row, n_row;
    logic [4:0]  r_fmt, n_fmt;
    logic [26:0] r_rawrem, n_rawrem;
    logic [4:0]  r_rescnt, n_rescnt;
    logic [3:0]  r_levels;
    logic [11:0] r_rows;
    t_sym        r_q, n_q;
    logic [1:0]  r_qi, n_qi;
    t_res        r_p, n_p;
    logic        r_p_valid, n_p_valid;
    t_res        r_o;
    logic        r_o_valid;

    t_sym        sym;
    logic        go, out_free, push, prod, endblk, finish;
    t_res        res;
    logic [4:0]  take_n;
    logic        do_take;
    logic [15:0] mul_k;
    logic [31:0] mul_full;
    logic [14:0] band_last;
    logic [26:0] raw_total;
    logic [26:0] raw_idx;
    logic [11:0] rows_left;
    logic [11:0] zrun_n;
    logic [4:0]  need;

    sbcu_symdec u_symdec (
        .i_bits (r_buf[15:0]),
        .i_fmt  (r_fmt),
        .o_sym  (sym)
    );

    assign out_free  = !r_o_valid || !i_stall;
    assign go        = (r_state != S_IDLE) && (!r_p_valid || out_free);
    assign band_last = 15'((16'd1 << r_levels) - 16'd1);
    assign raw_total = 27'({15'd0, r_rows} << r_levels);
    assign raw_idx   = raw_total - r_rawrem;
    assign rows_left = r_rows - r_row;
    assign need      = need_bits(r_fmt);

    // Shared multiplier: level index times step, low half kept.
    always_comb begin
        case (r_qi)
            2'd1:    mul_k = r_q.k1;
            2'd2:    mul_k = r_q.k2;
            default: mul_k = r_q.k0;
        endcase
    end
    assign mul_full = mul_k * r_step;

    assign zrun_n = ({10'd0, r_q.zrun} > rows_left) ? rows_left : {10'd0, r_q.zrun};

    // Sequencer: one parse action per cycle while a waiting result does not hold it.
    always_comb begin
        n_state  = r_state;
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        n_step   = r_step;
        n_band   = r_band;
        n_row    = r_row;
        n_fmt    = r_fmt;
        n_rawrem = r_rawrem;
        n_rescnt = r_rescnt;
        n_q      = r_q;
        n_qi     = r_qi;
        prod     = 1'b0;
        endblk   = 1'b0;
        finish   = 1'b0;
        do_take  = 1'b0;
        take_n   = 5'd0;
        res      = '0;
        res.run_len = 12'd1;

        if (r_state == S_IDLE) begin
            if (i_valid) begin
                n_buf    = r_buf | ({24'd0, i_byte_in} << r_cnt[4:0]);
                n_cnt    = r_cnt + 6'd8;
                n_rescnt = 5'd0;
                n_state  = S_LOOP;
            end
        end else if (go && r_state == S_LEVEL) begin
            // Emit one value of the decoded symbol.
            if (r_row < r_rows) begin
                prod     = 1'b1;
                res.band = r_band;
                res.row  = r_row;
                if (r_q.is_zero) begin
                    res.run_len = zrun_n;
                    n_row       = r_row + zrun_n;
                end else begin
                    res.coeff = {{16{mul_full[15]}}, mul_full[15:0]};
                    n_row     = r_row + 12'd1;
                end
            end
            if (r_qi == r_q.count - 2'd1) begin
                n_state = S_LOOP;
                if (n_row >= r_rows) begin
                    if (r_band >= band_last) begin
                        endblk  = 1'b1;
                        n_phase = PH_EXP;
                    end else begin
                        n_band  = r_band + 15'd1;
                        n_phase = PH_CODE;
                    end
                end
            end else begin
                n_qi = r_qi + 2'd1;
            end
        end else if (go) begin
            if (r_rescnt > RES_LIMIT) begin
                finish = 1'b1;
            end else begin
                case (r_phase)
                    PH_EXP: begin
                        if (r_cnt < 6'd4) finish = 1'b1;
                        else begin
                            do_take = 1'b1; take_n = 5'd4; n_phase = PH_STEP;
                        end
                    end
                    PH_STEP: begin
                        if (r_cnt < 6'd16) finish = 1'b1;
                        else begin
                            n_step  = r_buf[15:0];
                            do_take = 1'b1; take_n = 5'd16;
                            n_band  = 15'd0;
                            n_phase = PH_CODE;
                        end
                    end
                    PH_CODE: begin
                        if (r_cnt < 6'd5) finish = 1'b1;
                        else begin
                            do_take = 1'b1; take_n = 5'd5;
                            n_fmt   = r_buf[4:0];
                            n_row   = 12'd0;
                            res.band = r_band;
                            if (r_buf[4:0] == FMT_ZERO) begin
                                if (r_rows != 12'd0) begin
                                    prod        = 1'b1;
                                    res.run_len = r_rows;
                                end
                                if (r_band >= band_last) begin
                                    endblk  = 1'b1;
                                    n_phase = PH_EXP;
                                end else begin
                                    n_band  = r_band + 15'd1;
                                    n_phase = PH_CODE;
                                end
                            end else if (r_buf[4:0] == FMT_RAW) begin
                                n_rawrem = raw_total;
                                n_phase  = PH_RAW;
                            end else if (need_bits(r_buf[4:0]) == 5'd0) begin
                                prod         = 1'b1;
                                res.bad_code = 1'b1;
                                endblk       = 1'b1;
                                n_phase      = PH_EXP;
                            end else begin
                                n_phase = PH_BAND;
                            end
                        end
                    end
                    PH_BAND: begin
                        if (r_row >= r_rows) begin
                            if (r_band >= band_last) begin
                                endblk  = 1'b1;
                                n_phase = PH_EXP;
                            end else begin
                                n_band  = r_band + 15'd1;
                                n_phase = PH_CODE;
                            end
                        end else if (r_cnt < {1'b0, need}) begin
                            finish = 1'b1;
                        end else begin
                            do_take = 1'b1; take_n = sym.take;
                            n_q     = sym;
                            n_qi    = 2'd0;
                            n_state = S_LEVEL;
                        end
                    end
                    PH_RAW: begin
                        if (r_rawrem == 27'd0) begin
                            endblk  = 1'b1;
                            n_phase = PH_EXP;
                        end else if (r_cnt < 6'd16) begin
                            finish = 1'b1;
                        end else begin
                            prod         = 1'b1;
                            res.coeff    = {{16{r_buf[15]}}, r_buf[15:0]} << r_levels;
                            res.band     = raw_idx[14:0];
                            res.row      = raw_idx[26:15];
                            res.raw_mode = 1'b1;
                            do_take      = 1'b1; take_n = 5'd16;
                            n_rawrem     = r_rawrem - 27'd1;
                            if (r_rawrem == 27'd1) begin
                                endblk  = 1'b1;
                                n_phase = PH_EXP;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_EXP;
                    end
                endcase
            end
            if (finish) n_state = S_IDLE;
        end

        if (do_take) begin
            n_buf = r_buf >> take_n;
            n_cnt = r_cnt - {1'b0, take_n};
        end
        if (prod) n_rescnt = r_rescnt + 5'd1;
    end

    // Pending result: held back until it is known whether it closes a block.
    assign push = r_p_valid && (prod || finish);

    always_comb begin
        n_p       = r_p;
        n_p_valid = r_p_valid;
        if (prod) begin
            n_p           = res;
            n_p.block_end = endblk;
            n_p_valid     = 1'b1;
        end else if (finish) begin
            n_p_valid = 1'b0;
        end else if (endblk) begin
            n_p.block_end = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_buf     <= '0;
            r_cnt     <= '0;
            r_phase   <= PH_EXP;
            r_step    <= '0;
            r_band    <= '0;
            r_row     <= '0;
            r_fmt     <= '0;
            r_rawrem  <= '0;
            r_rescnt  <= '0;
            r_qi      <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_levels  <= '0;
            r_rows    <= '0;
        end else begin
            r_state   <= n_state;
            r_buf     <= n_buf;
            r_cnt     <= n_cnt;
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_band    <= n_band;
            r_row     <= n_row;
            r_fmt     <= n_fmt;
            r_rawrem  <= n_rawrem;
            r_rescnt  <= n_rescnt;
            r_qi      <= n_qi;
            r_p_valid <= n_p_valid;
            if (push) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
            // Configuration transfer.
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_LEVELS) r_levels <= i_cfg_data[3:0];
                else if (i_cfg_index == REG_ROWS) r_rows <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        r_p <= n_p;
        if (push) r_o <= r_p;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_coeff     = r_o.coeff;
    assign o_band      = r_o.band;
    assign o_row       = r_o.row;
    assign o_run_len   = r_o.run_len;
    assign o_raw_mode  = r_o.raw_mode;
    assign o_bad_code  = r_o.bad_code;
    assign o_block_end = r_o.block_end;
    assign o_cfg_ready = 1'b1;

    // No result may be left pending once the block waits for a byte.
    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_p_valid)
        else $error("pending result left behind at idle");

    // The bit buffer never holds more than 32 bits.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'd32)
        else $error("bit count overflow");

    // A byte never yields more than 24 results, the limit plus one decoded symbol.
    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rescnt <= 5'd24)
        else $error("too many results for one byte");

    // A pending result moves out only into a free output register.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result overwritten at the output");

endmodule
